// File: rtl/pseudo_mersenne_modmul_256_assert.svh
`ifndef PSEUDO_MERSENNE_MODMUL_256_ASSERT_SVH
`define PSEUDO_MERSENNE_MODMUL_256_ASSERT_SVH

// same-cycle implication on clock, disabled in reset
`define PMM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pmm assertion failed");

// next-cycle implication on clock, disabled in reset
`define PMM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pmm assertion failed");

`endif

// File: rtl/pmm256_pkg.sv
package pmm256_pkg;

   localparam int NUM_STAGES = 13;

   localparam logic [255:0] P_SECP =
      256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
   localparam logic [255:0] P_ED =
      256'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFED;

   // small part of the fold constant
   localparam logic [9:0] K_SECP = 10'd977;
   localparam logic [9:0] K_ED   = 10'd38;

   // full fold constant 2^256 mod p
   localparam logic [255:0] C_SECP = 256'h1_000003D1;
   localparam logic [255:0] C_ED   = 256'd38;

   localparam logic MODE_SECP = 1'b0;
   localparam logic MODE_ED   = 1'b1;

   typedef struct packed {
      logic         mode;
      logic [255:0] value;
   } red_in_type;

endpackage

// File: rtl/pmm256_reduce.sv
module pmm256_reduce
   import pmm256_pkg::*;
(
   input  red_in_type   red_in,
   output logic [255:0] red_out
);

   logic [255:0] prime;
   logic [257:0] d1;
   logic [257:0] d2;

   always_comb begin
      prime = (red_in.mode == MODE_ED) ? P_ED : P_SECP;
      d1 = {2'b0, red_in.value} - {2'b0, prime};
      d2 = {2'b0, red_in.value} - {1'b0, prime, 1'b0};
      if (!d2[257]) begin
         red_out = d2[255:0];
      end else if (!d1[257]) begin
         red_out = d1[255:0];
      end else begin
         red_out = red_in.value;
      end
   end

endmodule

// File: rtl/pseudo_mersenne_modmul_256.sv
// 256-bit modular multiplier for pseudo-Mersenne primes.
// Input channel req_*: two operands a and b, four 64-bit little-endian words
// each, moved by a valid/ready transfer. Result channel rsp_*: the product
// (a * b) mod p, fully reduced into [0, p), as four words.
// csr_wr_en / csr_wr_data select the prime: 0 is 2^256 - 2^32 - 977,
// 1 is 2^255 - 19. Write it only while the pipeline is empty.
// One item can enter every cycle unless rsp_ready stalls the pipeline; an
// item passes in turn through the 13 register stages, the first of which
// captures the transfer: 32x32 partial products, a four-level add tree, two
// folds of the high half, a carry fold and a final select against p and 2p.
// Each stage holds a valid bit; when rsp_ready is low the stages fill up and
// bubbles close, so req_ready drops only once every stage holds an item.
// Nothing is lost or repeated under a stall.
// Reset clears all valid bits and sets the prime select to 0.
module pseudo_mersenne_modmul_256
   import pmm256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_a_word0,
   input  logic [63:0] req_a_word1,
   input  logic [63:0] req_a_word2,
   input  logic [63:0] req_a_word3,
   input  logic [63:0] req_b_word0,
   input  logic [63:0] req_b_word1,
   input  logic [63:0] req_b_word2,
   input  logic [63:0] req_b_word3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_prod_word0,
   output logic [63:0] rsp_prod_word1,
   output logic [63:0] rsp_prod_word2,
   output logic [63:0] rsp_prod_word3
);

   localparam int LAST = NUM_STAGES - 1;

   logic                  mode_ff;
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] md_ff;
   logic [NUM_STAGES-1:0] en;

   logic [255:0] a_ff, b_ff;
   logic [63:0]  pp_ff [8][8];
   logic [63:0]  pp_in [8][8];
   logic [287:0] row_ff [8];
   logic [287:0] row_in [8];
   logic [319:0] q_ff [4];
   logic [319:0] q_in [4];
   logic [383:0] h_ff [2];
   logic [383:0] h_in [2];
   logic [511:0] p_ff, p_in;
   logic [41:0]  e_ff [8];
   logic [41:0]  e_in [8];
   logic [255:0] l6_ff, hh6_ff;
   logic [9:0]   k5, k8;
   logic [255:0] ev7, od7;
   logic [289:0] s7_ff, s7_in;
   logic [288:0] t7_ff, t7_in;
   logic [290:0] f8_ff, f8_in;
   logic [34:0]  h9_ff;
   logic [44:0]  pr9_ff, pr9_in;
   logic [255:0] l9_ff;
   logic [257:0] f10_ff, f10_in;
   logic [255:0] f11_ff, f11_in;
   logic [255:0] c10;
   red_in_type   red_in;
   logic [255:0] red_out;
   logic [255:0] prod_ff;
   logic [255:0] rsp_prime;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SECP;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // stage enables, a stage moves when empty or when the next one moves
   always_comb begin
      en[LAST] = !v_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         md_ff[0] <= mode_ff;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            md_ff[k] <= md_ff[k-1];
         end
      end
   end

   // datapath next values
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            pp_in[i][j] = a_ff[32*i +: 32] * b_ff[32*j +: 32];
         end
         row_in[i] = {32'b0, pp_ff[i][6], pp_ff[i][4], pp_ff[i][2], pp_ff[i][0]}
                   + {pp_ff[i][7], pp_ff[i][5], pp_ff[i][3], pp_ff[i][1], 32'b0};
      end
      for (int k = 0; k < 4; k++) begin
         q_in[k] = {32'b0, row_ff[2*k]} + {row_ff[2*k+1], 32'b0};
      end
      for (int m = 0; m < 2; m++) begin
         h_in[m] = {64'b0, q_ff[2*m]} + {q_ff[2*m+1], 64'b0};
      end
      p_in = {128'b0, h_ff[0]} + {h_ff[1], 128'b0};

      k5 = (md_ff[5] == MODE_ED) ? K_ED : K_SECP;
      for (int i = 0; i < 8; i++) begin
         e_in[i] = p_ff[256 + 32*i +: 32] * k5;
      end

      ev7 = {22'b0, e_ff[6], 22'b0, e_ff[4], 22'b0, e_ff[2], 22'b0, e_ff[0]};
      od7 = {22'b0, e_ff[7], 22'b0, e_ff[5], 22'b0, e_ff[3], 22'b0, e_ff[1]};
      s7_in = {34'b0, ev7} + {2'b0, od7, 32'b0};
      t7_in = {33'b0, l6_ff}
            + ((md_ff[6] == MODE_ED) ? 289'b0 : {1'b0, hh6_ff, 32'b0});

      f8_in = {1'b0, s7_ff} + {2'b0, t7_ff};

      k8 = (md_ff[8] == MODE_ED) ? K_ED : K_SECP;
      pr9_in = f8_ff[290:256] * k8;

      f10_in = {2'b0, l9_ff} + {213'b0, pr9_ff}
             + ((md_ff[9] == MODE_ED) ? 258'b0 : {191'b0, h9_ff, 32'b0});

      c10 = (md_ff[10] == MODE_ED) ? C_ED : C_SECP;
      f11_in = f10_ff[255:0] + (f10_ff[256] ? c10 : 256'b0);

      red_in.mode  = md_ff[11];
      red_in.value = f11_ff;
   end

   pmm256_reduce u_reduce (
      .red_in  (red_in),
      .red_out (red_out)
   );

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff <= {req_a_word3, req_a_word2, req_a_word1, req_a_word0};
         b_ff <= {req_b_word3, req_b_word2, req_b_word1, req_b_word0};
      end
      if (en[1]) begin
         pp_ff <= pp_in;
      end
      if (en[2]) begin
         row_ff <= row_in;
      end
      if (en[3]) begin
         q_ff <= q_in;
      end
      if (en[4]) begin
         h_ff <= h_in;
      end
      if (en[5]) begin
         p_ff <= p_in;
      end
      if (en[6]) begin
         e_ff   <= e_in;
         l6_ff  <= p_ff[255:0];
         hh6_ff <= p_ff[511:256];
      end
      if (en[7]) begin
         s7_ff <= s7_in;
         t7_ff <= t7_in;
      end
      if (en[8]) begin
         f8_ff <= f8_in;
      end
      if (en[9]) begin
         h9_ff  <= f8_ff[290:256];
         pr9_ff <= pr9_in;
         l9_ff  <= f8_ff[255:0];
      end
      if (en[10]) begin
         f10_ff <= f10_in;
      end
      if (en[11]) begin
         f11_ff <= f11_in;
      end
      if (en[12]) begin
         prod_ff <= red_out;
      end
   end

   assign req_ready      = en[0];
   assign rsp_valid      = v_ff[LAST];
   assign rsp_prod_word0 = prod_ff[63:0];
   assign rsp_prod_word1 = prod_ff[127:64];
   assign rsp_prod_word2 = prod_ff[191:128];
   assign rsp_prod_word3 = prod_ff[255:192];
   assign rsp_prime      = (md_ff[LAST] == MODE_ED) ? P_ED : P_SECP;

`include "pseudo_mersenne_modmul_256_assert.svh"

   `PMM_ASSERT_NOW(a_result_reduced, rsp_valid, prod_ff < rsp_prime)
   `PMM_ASSERT_NOW(a_stall_only_when_full, !req_ready, &v_ff)
   `PMM_ASSERT_NEXT(a_transfer_enters, req_valid && req_ready, v_ff[0])

endmodule

// File: verif/tb_pseudo_mersenne_modmul_256.sv
`timescale 1ns / 1ps

module tb_pseudo_mersenne_modmul_256
   import pmm256_pkg::*;
();

   typedef struct {
      logic [255:0] a;
      logic [255:0] b;
      logic         mode;
      logic         has_expected;
      logic [255:0] expected;
   } vector_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_a_word0, req_a_word1, req_a_word2, req_a_word3;
   logic [63:0] req_b_word0, req_b_word1, req_b_word2, req_b_word3;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_prod_word0, rsp_prod_word1, rsp_prod_word2, rsp_prod_word3;

   logic [255:0] product_queue[$];
   logic         curve_mode_model;
   int           error_count;
   int           transfers_in;
   int           transfers_out;
   bit           hold_off_request;

   pseudo_mersenne_modmul_256 i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_word0(req_a_word0), .req_a_word1(req_a_word1),
      .req_a_word2(req_a_word2), .req_a_word3(req_a_word3),
      .req_b_word0(req_b_word0), .req_b_word1(req_b_word1),
      .req_b_word2(req_b_word2), .req_b_word3(req_b_word3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_prod_word0(rsp_prod_word0), .rsp_prod_word1(rsp_prod_word1),
      .rsp_prod_word2(rsp_prod_word2), .rsp_prod_word3(rsp_prod_word3)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

   // exact modular product, done with wide integers
   function automatic logic [255:0] modmul(logic [255:0] a, logic [255:0] b, logic mode);
      logic [511:0] prime;
      logic [511:0] wide;
      prime = (mode == MODE_ED) ? {256'd0, P_ED} : {256'd0, P_SECP};
      wide = ({256'd0, a} * {256'd0, b}) % prime;
      return wide[255:0];
   endfunction

   function automatic logic [255:0] random_operand(int kind);
      logic [255:0] v;
      for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
      case (kind)
         0: v = P_SECP - 256'($urandom_range(0, 3)) + 256'($urandom_range(0, 6));
         1: v = P_ED - 256'($urandom_range(0, 3)) + 256'($urandom_range(0, 6));
         2: v = '1 - 256'($urandom_range(0, 40));
         3: v = 256'($urandom_range(0, 40));
         4: v = v >> $urandom_range(0, 255);
         default: ;
      endcase
      return v;
   endfunction

   task automatic write_mode(logic value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      curve_mode_model = value;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (product_queue.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);
   endtask

   task automatic send_item(logic [255:0] a, logic [255:0] b, logic [255:0] expected);
      int idle;
      idle = $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_a_word3, req_a_word2, req_a_word1, req_a_word0} <= a;
      {req_b_word3, req_b_word2, req_b_word1, req_b_word0} <= b;
      do @(posedge clock); while (!req_ready);
      product_queue.push_back(expected);
      transfers_in++;
   endtask

   // receiver
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off_request = 1'b0;
         end
         else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            logic [255:0] got;
            logic [255:0] want;
            got = {rsp_prod_word3, rsp_prod_word2, rsp_prod_word1, rsp_prod_word0};
            transfers_out++;
            if (product_queue.size() == 0) begin
               $display("%0t unexpected transfer: expected none, actual %h", $time, got);
               error_count++;
            end
            else begin
               want = product_queue.pop_front();
               for (int w = 0; w < 4; w++)
                  if (got[64*w +: 64] !== want[64*w +: 64]) begin
                     $display("%0t prod_word%0d mismatch: expected %h, actual %h",
                        $time, w, want[64*w +: 64], got[64*w +: 64]);
                     error_count++;
                  end
            end
         end
      end
   end

   initial begin
      vector_row_type table_rows [17];
      logic [255:0] a;
      logic [255:0] b;
      logic         mode;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      {req_a_word3, req_a_word2, req_a_word1, req_a_word0} = '0;
      {req_b_word3, req_b_word2, req_b_word1, req_b_word0} = '0;
      error_count = 0;
      transfers_in = 0;
      transfers_out = 0;
      hold_off_request = 1'b0;
      curve_mode_model = MODE_SECP;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      table_rows = '{
         '{256'd0, 256'd0, MODE_SECP, 1'b1, 256'd0},
         '{256'd1, 256'd1, MODE_SECP, 1'b1, 256'd1},
         '{P_SECP, 256'd5, MODE_SECP, 1'b1, 256'd0},
         '{P_SECP + 256'd1, 256'd7, MODE_SECP, 1'b1, 256'd7},
         '{P_SECP - 256'd1, P_SECP - 256'd1, MODE_SECP, 1'b1, 256'd1},
         '{'1, '1, MODE_SECP, 1'b0, '0},
         '{'1, 256'd1, MODE_SECP, 1'b0, '0},
         '{256'h1 << 255, 256'd2, MODE_SECP, 1'b0, '0},
         '{256'd0, 256'd0, MODE_ED, 1'b1, 256'd0},
         '{256'd1, 256'd1, MODE_ED, 1'b1, 256'd1},
         '{P_ED, 256'd9, MODE_ED, 1'b1, 256'd0},
         '{P_ED + 256'd1, 256'd3, MODE_ED, 1'b1, 256'd3},
         '{P_ED - 256'd1, P_ED - 256'd1, MODE_ED, 1'b1, 256'd1},
         '{'1, '1, MODE_ED, 1'b0, '0},
         '{'1, 256'd1, MODE_ED, 1'b0, '0},
         '{256'h1 << 255, 256'd1, MODE_ED, 1'b1, 256'd19},
         '{P_ED << 1, 256'd1, MODE_ED, 1'b0, '0}
      };

      foreach (table_rows[i]) begin
         if (table_rows[i].mode != curve_mode_model) begin
            wait_drained();
            write_mode(table_rows[i].mode);
         end
         send_item(table_rows[i].a, table_rows[i].b,
            table_rows[i].has_expected ? table_rows[i].expected :
            modmul(table_rows[i].a, table_rows[i].b, curve_mode_model));
      end

      // random phases alternate the prime, one phase with a long receiver stall
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         mode = (phase % 2 == 0) ? MODE_SECP : MODE_ED;
         write_mode(mode);
         if (phase == 2) hold_off_request = 1'b1;
         for (int n = 0; n < 150; n++) begin
            a = random_operand($urandom_range(0, 9));
            b = random_operand($urandom_range(0, 9));
            send_item(a, b, modmul(a, b, curve_mode_model));
         end
      end

      wait_drained();
      $display("covered %0d transfers in, %0d out, both primes, stalls and backpressure",
         transfers_in, transfers_out);
      if (error_count == 0) begin
         $display("simulation ok");
      end
      else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/pmm256_pkg.sv
rtl/pmm256_reduce.sv
rtl/pseudo_mersenne_modmul_256.sv
verif/tb_pseudo_mersenne_modmul_256.sv
